// ----- rtl/nsfc_pkg.sv -----
package nsfc_pkg;

   // Number of bytes of a sentence that take part in the classification,
   // the leading dollar included.
   localparam int PREFIX_LEN = 6;

   // Characters with a framing meaning.
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // Sentence formatter codes, three characters each.
   localparam logic [23:0] FMT_GGA = "GGA";
   localparam logic [23:0] FMT_RMC = "RMC";
   localparam logic [23:0] FMT_GLL = "GLL";
   localparam logic [23:0] FMT_VTG = "VTG";

   // Sentence type codes reported in the result.
   localparam logic [2:0] TYPE_OTHER = 3'd0;
   localparam logic [2:0] TYPE_GGA   = 3'd1;
   localparam logic [2:0] TYPE_RMC   = 3'd2;
   localparam logic [2:0] TYPE_GLL   = 3'd3;
   localparam logic [2:0] TYPE_VTG   = 3'd4;

   // Configuration register indexes and reset values.
   localparam int         CSR_INDEX_WIDTH = 4;
   localparam int         CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TALKER_ID  = 4'd1;
   localparam logic [6:0]  MAX_LENGTH_RESET = 7'd75;
   localparam logic [15:0] TALKER_ID_RESET  = 16'h474E;

   // One result, as it travels from the framer to the output buffer.
   typedef struct packed {
      logic       checksum_ok;
      logic [2:0] sentence_type;
      logic [7:0] computed_checksum;
      logic [6:0] sentence_length;
   } rsp_type;

endpackage

// ----- rtl/nsfc_framer.sv -----
module nsfc_framer
   import nsfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_valid,
   input  logic [7:0]  rx_byte,
   input  logic [6:0]  max_length,
   input  logic [15:0] talker_id,
   output logic        close_valid,
   output rsp_type     close_data
);

   logic [6:0] char_count_ff,        char_count_in;
   logic       first_is_dollar_ff,   first_is_dollar_in;
   logic [7:0] running_xor_ff,       running_xor_in;
   logic       star_seen_ff,         star_seen_in;
   logic       zero_byte_seen_ff,    zero_byte_seen_in;
   logic [1:0] digits_after_star_ff, digits_after_star_in;
   logic [7:0] check_hi_ff,          check_hi_in;
   logic [7:0] check_lo_ff,          check_lo_in;
   logic [7:0] prefix_ff [PREFIX_LEN-1];
   logic [7:0] prefix_in [PREFIX_LEN-1];

   logic       checksum_ok;
   logic [2:0] sentence_type;
   logic [23:0] fmt_code;

   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      logic [7:0] digit;
      if (nib < 4'd10) begin
         digit = 8'h30 + {4'd0, nib};
      end else begin
         digit = 8'h41 + {4'd0, nib} - 8'd10;
      end
      return digit;
   endfunction

   // Check and classification of the sentence held so far.
   assign checksum_ok = first_is_dollar_ff && star_seen_ff && !zero_byte_seen_ff &&
                        (check_hi_ff == hex_upper(running_xor_ff[7:4])) &&
                        (check_lo_ff == hex_upper(running_xor_ff[3:0]));

   assign fmt_code = {prefix_ff[2], prefix_ff[3], prefix_ff[4]};

   always_comb begin
      sentence_type = TYPE_OTHER;
      if (first_is_dollar_ff && (prefix_ff[0] == talker_id[15:8]) &&
          (prefix_ff[1] == talker_id[7:0])) begin
         if (fmt_code == FMT_GGA) begin
            sentence_type = TYPE_GGA;
         end else if (fmt_code == FMT_RMC) begin
            sentence_type = TYPE_RMC;
         end else if (fmt_code == FMT_GLL) begin
            sentence_type = TYPE_GLL;
         end else if (fmt_code == FMT_VTG) begin
            sentence_type = TYPE_VTG;
         end
      end
   end

   always_comb begin
      close_data.checksum_ok       = checksum_ok;
      close_data.sentence_type     = sentence_type;
      close_data.computed_checksum = first_is_dollar_ff ? running_xor_ff : 8'd0;
      close_data.sentence_length   = char_count_ff;
   end

   always_comb begin
      char_count_in        = char_count_ff;
      first_is_dollar_in   = first_is_dollar_ff;
      running_xor_in       = running_xor_ff;
      star_seen_in         = star_seen_ff;
      zero_byte_seen_in    = zero_byte_seen_ff;
      digits_after_star_in = digits_after_star_ff;
      check_hi_in          = check_hi_ff;
      check_lo_in          = check_lo_ff;
      for (int k = 0; k < PREFIX_LEN - 1; k++) begin
         prefix_in[k] = prefix_ff[k];
      end
      close_valid = 1'b0;

      if (byte_valid) begin
         if (rx_byte == CHAR_DOLLAR) begin
            // A dollar always opens a fresh sentence as its first byte.
            char_count_in        = 7'd1;
            first_is_dollar_in   = 1'b1;
            running_xor_in       = 8'd0;
            star_seen_in         = 1'b0;
            zero_byte_seen_in    = 1'b0;
            digits_after_star_in = 2'd0;
            check_hi_in          = 8'd0;
            check_lo_in          = 8'd0;
            for (int k = 0; k < PREFIX_LEN - 1; k++) begin
               prefix_in[k] = 8'd0;
            end
         end else if ((rx_byte != CHAR_NEWLINE) && (char_count_ff < max_length)) begin
            char_count_in = char_count_ff + 7'd1;
            if (char_count_ff == 7'd0) begin
               first_is_dollar_in = 1'b0;
            end else begin
               for (int k = 0; k < PREFIX_LEN - 1; k++) begin
                  if (char_count_ff == 7'(k + 1)) begin
                     prefix_in[k] = rx_byte;
                  end
               end
               if (!star_seen_ff && !zero_byte_seen_ff) begin
                  if (rx_byte == CHAR_NUL) begin
                     zero_byte_seen_in = 1'b1;
                  end else if (rx_byte == CHAR_STAR) begin
                     star_seen_in = 1'b1;
                  end else begin
                     running_xor_in = running_xor_ff ^ rx_byte;
                  end
               end else if (star_seen_ff && (digits_after_star_ff < 2'd2)) begin
                  if (digits_after_star_ff == 2'd0) begin
                     check_hi_in = rx_byte;
                  end else begin
                     check_lo_in = rx_byte;
                  end
                  digits_after_star_in = digits_after_star_ff + 2'd1;
               end
            end
         end else begin
            // Newline or full buffer: report the sentence and drop the byte.
            close_valid          = 1'b1;
            char_count_in        = 7'd0;
            first_is_dollar_in   = 1'b0;
            running_xor_in       = 8'd0;
            star_seen_in         = 1'b0;
            zero_byte_seen_in    = 1'b0;
            digits_after_star_in = 2'd0;
            check_hi_in          = 8'd0;
            check_lo_in          = 8'd0;
            for (int k = 0; k < PREFIX_LEN - 1; k++) begin
               prefix_in[k] = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff        <= 7'd0;
         first_is_dollar_ff   <= 1'b0;
         running_xor_ff       <= 8'd0;
         star_seen_ff         <= 1'b0;
         zero_byte_seen_ff    <= 1'b0;
         digits_after_star_ff <= 2'd0;
         check_hi_ff          <= 8'd0;
         check_lo_ff          <= 8'd0;
         for (int k = 0; k < PREFIX_LEN - 1; k++) begin
            prefix_ff[k] <= 8'd0;
         end
      end else begin
         char_count_ff        <= char_count_in;
         first_is_dollar_ff   <= first_is_dollar_in;
         running_xor_ff       <= running_xor_in;
         star_seen_ff         <= star_seen_in;
         zero_byte_seen_ff    <= zero_byte_seen_in;
         digits_after_star_ff <= digits_after_star_in;
         check_hi_ff          <= check_hi_in;
         check_lo_ff          <= check_lo_in;
         for (int k = 0; k < PREFIX_LEN - 1; k++) begin
            prefix_ff[k] <= prefix_in[k];
         end
      end
   end

endmodule

// ----- rtl/nsfc_rsp_buf.sv -----
module nsfc_rsp_buf
   import nsfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    out_valid_ff,  out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff,   out_data_in;
   rsp_type skid_data_ff,  skid_data_in;

   // The skid slot only fills while the output slot is held.
   assign space     = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push_valid;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push_valid;
            out_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- rtl/nmea_sentence_framer_checker.sv -----
// NMEA 0183 sentence framer and checksum checker. Received bytes enter one
// transaction at a time on the req_ channel; a dollar opens a new sentence,
// and a newline, or any byte other than a dollar that arrives once max_length
// bytes are held, closes it and produces exactly one rsp_ transaction carrying
// the checksum verdict, the sentence type, the XOR over the bytes between
// dollar and star, and the number of bytes kept. The closing byte is not
// counted. The block takes one byte in every clock cycle while req_ready is
// high: each byte updates the sentence registers through a single level of
// XOR and compare logic, and a closing byte's result reaches rsp_valid from
// the registered output slot, after waiting in a skid slot behind it if the
// output slot is held. So req_ready drops only while both slots hold
// results that have not been taken. The csr_ port is always ready; it should
// be written only while no sentence result is outstanding.
module nmea_sentence_framer_checker
   import nsfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_checksum_ok,
   output logic [2:0]                 rsp_sentence_type,
   output logic [7:0]                 rsp_computed_checksum,
   output logic [6:0]                 rsp_sentence_length,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [6:0]  max_length_ff;
   logic [15:0] talker_id_ff;
   logic        byte_accept;
   logic        close_valid;
   rsp_type     close_data;
   rsp_type     rsp_data;

   // Configuration registers; writes to unused indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         talker_id_ff  <= TALKER_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_LENGTH: max_length_ff <= csr_wdata[6:0];
            CSR_TALKER_ID:  talker_id_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // A byte is taken whenever a result slot is free, so a closing byte
   // always has somewhere to put its result.
   assign byte_accept = req_valid && req_ready;

   nsfc_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_accept),
      .rx_byte     (req_rx_byte),
      .max_length  (max_length_ff),
      .talker_id   (talker_id_ff),
      .close_valid (close_valid),
      .close_data  (close_data)
   );

   nsfc_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (close_valid),
      .push_data  (close_data),
      .space      (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_checksum_ok       = rsp_data.checksum_ok;
   assign rsp_sentence_type     = rsp_data.sentence_type;
   assign rsp_computed_checksum = rsp_data.computed_checksum;
   assign rsp_sentence_length   = rsp_data.sentence_length;

   // A newline always closes a sentence, so a result must be waiting next.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_rx_byte == CHAR_NEWLINE) |=> rsp_valid)
      else $error("newline transaction produced no result");

   // A dollar never closes a sentence: with nothing waiting, nothing appears.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_rx_byte == CHAR_DOLLAR) && !rsp_valid
      |=> !rsp_valid)
      else $error("dollar transaction produced a result");

   // Input back-pressure only arises from results that have not been taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // A passing sentence holds at least a dollar, a star and two digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> (rsp_sentence_length >= 7'd4))
      else $error("checksum passed on a sentence too short to carry one");

endmodule
